/* rtl/core/source_tokenizer_macros.svh */
// Assertion helpers shared by the tokenizer checks.
// All checks sample on clk_i and are disabled while rst_ni is low.
`ifndef SOURCE_TOKENIZER_MACROS_SVH
`define SOURCE_TOKENIZER_MACROS_SVH

// Check a property on the block clock.
`define STOK_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Check that a stalled beat keeps its valid and payload.
`define STOK_ASSERT_HOLD(lbl, vld, rdy, pay, msg) \
  `STOK_ASSERT(lbl, ((vld) && !(rdy)) |=> ((vld) && $stable(pay)), msg)

`endif

/* rtl/core/stok_pkg.sv */
// ----------------------------------------------------------------------------
// stok_pkg
// Types, character codes and class functions of the source tokenizer.
// ----------------------------------------------------------------------------
package stok_pkg;

  typedef enum logic [1:0] {
    KIND_IDENT  = 2'd0,
    KIND_NUMBER = 2'd1,
    KIND_SYMBOL = 2'd2,
    KIND_END    = 2'd3
  } kind_e;

  typedef enum logic [8:0] {
    PH_IDLE       = 9'b000000001,
    PH_IDENT      = 9'b000000010,
    PH_NUM_INT    = 9'b000000100,
    PH_NUM_FRAC   = 9'b000001000,
    PH_HELD       = 9'b000010000,
    PH_LINE       = 9'b000100000,
    PH_BLOCK      = 9'b001000000,
    PH_BLOCK_DASH = 9'b010000000,
    PH_DONE       = 9'b100000000
  } phase_e;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UZ     = 8'h5A;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LZ     = 8'h7A;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  symbol_byte;
    logic [31:0] start_offset;
    logic [15:0] token_len;
    logic [31:0] line_no;
    logic        ws_before;
    logic        nl_before;
    logic        last;
  } result_t;

  // All results caused by one source byte.
  typedef struct packed {
    logic    two;
    result_t first;
    result_t second;
  } entry_t;

  typedef struct packed {
    logic   valid;
    entry_t entry;
  } push_t;

  typedef struct packed {
    logic   valid;
    entry_t entry;
  } qhead_t;

  function automatic logic is_letter(input logic [7:0] c);
    return ((c >= CH_UA) && (c <= CH_UZ)) || ((c >= CH_LA) && (c <= CH_LZ));
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_0) && (c <= CH_9);
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

endpackage

/* rtl/core/stok_if.sv */
// ----------------------------------------------------------------------------
// stok_if
// Channel interfaces of the source tokenizer: source bytes in, tokens out.
// ----------------------------------------------------------------------------
interface stok_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;

  modport source (output valid, output ch, input ready);
  modport sink (input valid, input ch, output ready);
endinterface

interface stok_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  symbol_byte;
  logic [31:0] start_offset;
  logic [15:0] token_len;
  logic [31:0] line_no;
  logic        ws_before;
  logic        nl_before;
  logic        last;

  modport source (
    output valid, output kind, output symbol_byte, output start_offset,
    output token_len, output line_no, output ws_before, output nl_before,
    output last, input ready
  );
  modport sink (
    input valid, input kind, input symbol_byte, input start_offset,
    input token_len, input line_no, input ws_before, input nl_before,
    input last, output ready
  );
endinterface

/* rtl/core/stok_front.sv */
// ----------------------------------------------------------------------------
// stok_front
// Lexer state machine: takes one byte a beat and builds the results it causes.
// ----------------------------------------------------------------------------
module stok_front import stok_pkg::*; #(
  parameter int unsigned OFFSET_BITS = 32,
  parameter int unsigned LENGTH_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  stok_in_if.sink     in_i,
  input  logic        full_i,
  output push_t       push_o
);

  phase_e                 phase_q, phase_d;
  logic [7:0]             held_q, held_d;
  logic [OFFSET_BITS-1:0] off_q, off_d;
  logic [31:0]            line_q, line_d;
  logic [OFFSET_BITS-1:0] start_q, start_d;
  logic [LENGTH_BITS-1:0] len_q, len_d;
  logic                   ws_q, ws_d;
  logic                   nl_q, nl_d;

  logic       accept;
  logic [7:0] c;
  logic       again;
  logic       a_valid;
  result_t    a_res;
  logic       b_valid;
  result_t    b_res;
  result_t    end_res;
  logic [LENGTH_BITS-1:0] len_grow;

  assign in_i.ready = !full_i;
  assign accept     = in_i.valid && !full_i;
  assign c          = in_i.ch;
  assign len_grow   = (len_q == '1) ? len_q : len_q + 1'b1;

  always_comb begin
    end_res              = '0;
    end_res.kind         = KIND_END;
    end_res.start_offset = 32'(off_q);
    end_res.line_no      = line_q;
  end

  always_comb begin
    phase_d = phase_q;
    held_d  = held_q;
    off_d   = off_q;
    line_d  = line_q;
    start_d = start_q;
    len_d   = len_q;
    ws_d    = ws_q;
    nl_d    = nl_q;
    again   = 1'b0;
    a_valid = 1'b0;
    b_valid = 1'b0;
    b_res   = end_res;

    a_res              = '0;
    a_res.kind         = KIND_IDENT;
    a_res.start_offset = 32'(start_q);
    a_res.token_len    = 16'(len_q);
    a_res.line_no      = line_q;
    a_res.ws_before    = ws_q;
    a_res.nl_before    = nl_q;

    if (phase_q == PH_DONE) begin
      b_valid = 1'b1;
    end else begin
      if (c != CH_NUL) begin
        off_d = off_q + 1'b1;
      end
      case (phase_q)
        PH_IDENT: begin
          if (is_letter(c) || is_digit(c)) begin
            len_d = len_grow;
          end else begin
            a_valid = 1'b1;
            again   = 1'b1;
          end
        end
        PH_NUM_INT: begin
          if (is_digit(c)) begin
            len_d = len_grow;
          end else if (c == CH_DOT) begin
            len_d   = len_grow;
            phase_d = PH_NUM_FRAC;
          end else begin
            a_valid    = 1'b1;
            a_res.kind = KIND_NUMBER;
            again      = 1'b1;
          end
        end
        PH_NUM_FRAC: begin
          if (is_digit(c)) begin
            len_d = len_grow;
          end else begin
            a_valid    = 1'b1;
            a_res.kind = KIND_NUMBER;
            again      = 1'b1;
          end
        end
        PH_HELD: begin
          if ((c == CH_DASH) && (held_q == CH_DASH)) begin
            ws_d    = 1'b1;
            phase_d = PH_LINE;
          end else if ((c == CH_DASH) && (held_q == CH_LBRACE)) begin
            ws_d    = 1'b1;
            phase_d = PH_BLOCK;
          end else begin
            a_valid           = 1'b1;
            a_res.kind        = KIND_SYMBOL;
            a_res.symbol_byte = held_q;
            again             = 1'b1;
          end
        end
        PH_LINE: begin
          if (c == CH_NUL) begin
            b_valid = 1'b1;
            phase_d = PH_DONE;
          end else if (c == CH_NL) begin
            nl_d    = 1'b1;
            line_d  = line_q + 32'd1;
            phase_d = PH_IDLE;
          end
        end
        PH_BLOCK, PH_BLOCK_DASH: begin
          if (c == CH_NUL) begin
            b_valid = 1'b1;
            phase_d = PH_DONE;
          end else if ((c == CH_RBRACE) && (phase_q == PH_BLOCK_DASH)) begin
            phase_d = PH_IDLE;
          end else if (c == CH_DASH) begin
            phase_d = PH_BLOCK_DASH;
          end else begin
            if (c == CH_NL) begin
              nl_d   = 1'b1;
              line_d = line_q + 32'd1;
            end
            phase_d = PH_BLOCK;
          end
        end
        default: begin
          again = 1'b1;
        end
      endcase

      // a finished token takes the pending flags with it
      if (a_valid) begin
        ws_d = 1'b0;
        nl_d = 1'b0;
      end

      // handle the byte as the start of whatever follows
      if (again) begin
        phase_d = PH_IDLE;
        if (c == CH_NUL) begin
          b_valid = 1'b1;
          phase_d = PH_DONE;
        end else if (is_space(c)) begin
          ws_d = 1'b1;
          if (c == CH_NL) begin
            nl_d   = 1'b1;
            line_d = line_q + 32'd1;
          end
        end else begin
          start_d = off_q;
          len_d   = LENGTH_BITS'(1);
          if (is_letter(c)) begin
            phase_d = PH_IDENT;
          end else if (is_digit(c)) begin
            phase_d = PH_NUM_INT;
          end else if ((c == CH_DASH) || (c == CH_LBRACE)) begin
            held_d  = c;
            phase_d = PH_HELD;
          end else begin
            b_valid            = 1'b1;
            b_res.kind         = KIND_SYMBOL;
            b_res.symbol_byte  = c;
            b_res.start_offset = 32'(off_q);
            b_res.token_len    = 16'd1;
            b_res.ws_before    = a_valid ? 1'b0 : ws_q;
            b_res.nl_before    = a_valid ? 1'b0 : nl_q;
            ws_d               = 1'b0;
            nl_d               = 1'b0;
          end
        end
      end
    end
  end

  // pack the results of this byte, the final one marked last
  always_comb begin
    push_o       = '0;
    push_o.valid = accept && (a_valid || b_valid);
    if (a_valid) begin
      push_o.entry.first       = a_res;
      push_o.entry.first.last  = !b_valid;
      push_o.entry.two         = b_valid;
      push_o.entry.second      = b_res;
      push_o.entry.second.last = 1'b1;
    end else begin
      push_o.entry.first      = b_res;
      push_o.entry.first.last = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      held_q  <= '0;
      off_q   <= '0;
      line_q  <= 32'd1;
      start_q <= '0;
      len_q   <= '0;
      ws_q    <= 1'b0;
      nl_q    <= 1'b0;
    end else if (accept) begin
      phase_q <= phase_d;
      held_q  <= held_d;
      off_q   <= off_d;
      line_q  <= line_d;
      start_q <= start_d;
      len_q   <= len_d;
      ws_q    <= ws_d;
      nl_q    <= nl_d;
    end
  end

endmodule

/* rtl/core/stok_queue.sv */
// ----------------------------------------------------------------------------
// stok_queue
// Short FIFO of per-byte result groups between the lexer and the output side.
// ----------------------------------------------------------------------------
module stok_queue import stok_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  push_t  push_i,
  output logic   full_o,
  output qhead_t head_o,
  input  logic   pop_i
);

  entry_t            slots_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q;
  logic [QPTR_W-1:0] rd_ptr_q;
  logic [QCNT_W-1:0] count_q;
  logic              do_pop;

  assign full_o       = (count_q == QCNT_W'(QDEPTH));
  assign head_o.valid = (count_q != '0);
  assign head_o.entry = slots_q[rd_ptr_q];
  assign do_pop       = pop_i && head_o.valid;

  always_ff @(posedge clk_i) begin
    if (push_i.valid) begin
      slots_q[wr_ptr_q] <= push_i.entry;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i.valid) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      case ({push_i.valid, do_pop})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

/* rtl/core/stok_back.sv */
// ----------------------------------------------------------------------------
// stok_back
// Output stage: splits each result group into beats behind an output register.
// ----------------------------------------------------------------------------
module stok_back import stok_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  qhead_t     head_i,
  output logic       pop_o,
  stok_out_if.source out_o
);

  result_t out_q;
  logic    valid_q;
  logic    sel_q;
  logic    take;

  assign take  = !valid_q || out_o.ready;
  assign pop_o = take && head_i.valid && (!head_i.entry.two || sel_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      sel_q   <= 1'b0;
    end else if (take) begin
      valid_q <= head_i.valid;
      if (head_i.valid) begin
        sel_q <= head_i.entry.two && !sel_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && head_i.valid) begin
      out_q <= sel_q ? head_i.entry.second : head_i.entry.first;
    end
  end

  assign out_o.valid        = valid_q;
  assign out_o.kind         = out_q.kind;
  assign out_o.symbol_byte  = out_q.symbol_byte;
  assign out_o.start_offset = out_q.start_offset;
  assign out_o.token_len    = out_q.token_len;
  assign out_o.line_no      = out_q.line_no;
  assign out_o.ws_before    = out_q.ws_before;
  assign out_o.nl_before    = out_q.nl_before;
  assign out_o.last         = out_q.last;

endmodule

/* rtl/core/source_tokenizer.sv */
// ----------------------------------------------------------------------------
// source_tokenizer
// Streaming lexer: source bytes in, identifier/number/symbol tokens out.
// ----------------------------------------------------------------------------
// The block takes one source byte a beat and takes a new byte every cycle
// while its result queue has room. Most bytes cause no token or one token;
// a byte that ends a token and is itself a symbol or the end byte causes
// two, and those leave on two output beats in order. The output side is a
// single register, so it drains one token a cycle while the receiver is
// ready: sustained input runs at one byte a cycle as long as the token rate
// stays at or below one a cycle, and a four-group queue between lexer and
// output absorbs bursts. The tokens of an accepted byte pass first through a
// queue slot and then through the output register before they are handed
// over. Byte 0 ends the input; from then on every byte is answered with one
// more end marker until reset. Offsets count in OFFSET_BITS and wrap; token
// lengths saturate at all ones in LENGTH_BITS.
module source_tokenizer import stok_pkg::*; #(
  parameter int unsigned OFFSET_BITS = 32,
  parameter int unsigned LENGTH_BITS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  stok_in_if.sink    in_i,
  stok_out_if.source out_o
);

  push_t  push;
  qhead_t head;
  logic   full;
  logic   pop;

  // Front: classify each byte and advance the lexer state.
  stok_front #(
    .OFFSET_BITS (OFFSET_BITS),
    .LENGTH_BITS (LENGTH_BITS)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .full_i (full),
    .push_o (push)
  );

  // Queue: hold result groups so the lexer keeps going while output stalls.
  stok_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .full_o (full),
    .head_o (head),
    .pop_i  (pop)
  );

  // Back: drain each group one token beat at a time.
  stok_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .head_i (head),
    .pop_o  (pop),
    .out_o  (out_o)
  );

endmodule

/* rtl/core/stok_checker.sv */
// ----------------------------------------------------------------------------
// stok_checker
// Port-level checks of the source tokenizer, bound to the top level.
// ----------------------------------------------------------------------------
`include "source_tokenizer_macros.svh"

module stok_checker import stok_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [1:0]  out_kind_i,
  input logic [31:0] out_start_i,
  input logic        out_last_i
);

  logic        seen_in_q;
  logic        ended_q;
  logic        out_is_end;
  logic [34:0] out_beat;

  assign out_is_end = (out_kind_i == KIND_END);
  assign out_beat   = {out_kind_i, out_start_i, out_last_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_in_q <= 1'b0;
      ended_q   <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_i) begin
        seen_in_q <= 1'b1;
      end
      if (out_valid_i && out_ready_i && out_is_end) begin
        ended_q <= 1'b1;
      end
    end
  end

  `STOK_ASSERT_HOLD(a_out_hold, out_valid_i, out_ready_i, out_beat, "stalled token beat changed")

  `STOK_ASSERT(a_no_early_out, out_valid_i |-> seen_in_q, "token beat before any byte")

  `STOK_ASSERT(a_end_sticks, (ended_q && out_valid_i) |-> out_is_end, "token after end marker")

endmodule

bind source_tokenizer stok_checker u_stok_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_kind_i  (out_o.kind),
  .out_start_i (out_o.start_offset),
  .out_last_i  (out_o.last)
);

/* tb/source_tokenizer_test.sv */
// ----------------------------------------------------------------------------
// source_tokenizer_test
// Self-checking bench for the streaming source tokenizer. A short directed
// stream covers tokens, comments and held dashes and braces, then random
// token-shaped segments and noise follow, and one random ending closes the
// input. A scoreboard predicts every token beat and checks the outputs in
// order, while both sides of the block stall at random.
// ----------------------------------------------------------------------------
module source_tokenizer_test;
  timeunit 1ns;
  timeprecision 1ps;

  import stok_pkg::*;

  localparam logic [7:0] CH_VT     = 8'h0B;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam int         IDLE_MAX  = 2000;
  localparam int         DRAIN_CYC = 16;
  localparam int         RAND_BYTES = 600;

  // --------------------------------------------------------------------------
  // Scoreboard: predicts the tokens of each accepted byte, checks each beat
  // --------------------------------------------------------------------------
  class token_scoreboard;
    phase_e      phase;
    logic [7:0]  held;
    logic [31:0] offset;
    logic [31:0] line;
    logic [31:0] tok_start;
    logic [15:0] tok_len;
    bit          ws;
    bit          nl;
    result_t     expected_tokens[$];
    int          errors;

    function new();
      phase     = PH_IDLE;
      held      = '0;
      offset    = '0;
      line      = 32'd1;
      tok_start = '0;
      tok_len   = '0;
      ws        = 1'b0;
      nl        = 1'b0;
      errors    = 0;
    endfunction

    static function bit is_alpha(logic [7:0] c);
      return c inside {[CH_UA:CH_UZ], [CH_LA:CH_LZ]};
    endfunction

    static function bit is_num(logic [7:0] c);
      return c inside {[CH_0:CH_9]};
    endfunction

    static function bit is_blank(logic [7:0] c);
      return c == CH_SPACE || c inside {[CH_TAB:CH_CR]};
    endfunction

    function void extend();
      if (tok_len != '1) tok_len++;
    endfunction

    function result_t take_token(kind_e k, logic [7:0] sym);
      result_t r;
      r.kind         = k;
      r.symbol_byte  = sym;
      r.start_offset = tok_start;
      r.token_len    = tok_len;
      r.line_no      = line;
      r.ws_before    = ws;
      r.nl_before    = nl;
      r.last         = 1'b0;
      ws = 1'b0;
      nl = 1'b0;
      return r;
    endfunction

    function result_t end_marker();
      result_t r;
      r.kind         = KIND_END;
      r.symbol_byte  = '0;
      r.start_offset = offset;
      r.token_len    = '0;
      r.line_no      = line;
      r.ws_before    = 1'b0;
      r.nl_before    = 1'b0;
      r.last         = 1'b0;
      phase = PH_DONE;
      return r;
    endfunction

    function void count_newline();
      nl = 1'b1;
      line++;
    endfunction

    // Advance the lexer by one accepted byte and queue what it emits.
    function void note_byte(logic [7:0] c);
      logic [31:0] off;
      bit          again;
      result_t     batch[$];
      off   = offset;
      again = 1'b0;
      if (phase == PH_DONE) begin
        batch.push_back(end_marker());
      end else begin
        if (c != CH_NUL) offset = offset + 32'd1;
        case (phase)
          PH_IDENT: begin
            if (is_alpha(c) || is_num(c)) extend();
            else begin
              batch.push_back(take_token(KIND_IDENT, '0));
              again = 1'b1;
            end
          end
          PH_NUM_INT: begin
            if (is_num(c)) extend();
            else if (c == CH_DOT) begin
              extend();
              phase = PH_NUM_FRAC;
            end else begin
              batch.push_back(take_token(KIND_NUMBER, '0));
              again = 1'b1;
            end
          end
          PH_NUM_FRAC: begin
            if (is_num(c)) extend();
            else begin
              batch.push_back(take_token(KIND_NUMBER, '0));
              again = 1'b1;
            end
          end
          PH_HELD: begin
            if (c == CH_DASH && held == CH_DASH) begin
              ws    = 1'b1;
              phase = PH_LINE;
            end else if (c == CH_DASH && held == CH_LBRACE) begin
              ws    = 1'b1;
              phase = PH_BLOCK;
            end else begin
              batch.push_back(take_token(KIND_SYMBOL, held));
              again = 1'b1;
            end
          end
          PH_LINE: begin
            if (c == CH_NUL) batch.push_back(end_marker());
            else if (c == CH_NL) begin
              count_newline();
              phase = PH_IDLE;
            end
          end
          PH_BLOCK, PH_BLOCK_DASH: begin
            if (c == CH_NUL) batch.push_back(end_marker());
            else if (c == CH_RBRACE && phase == PH_BLOCK_DASH) phase = PH_IDLE;
            else if (c == CH_DASH) phase = PH_BLOCK_DASH;
            else begin
              if (c == CH_NL) count_newline();
              phase = PH_BLOCK;
            end
          end
          default: again = 1'b1;
        endcase

        if (again) begin
          phase = PH_IDLE;
          if (c == CH_NUL) begin
            batch.push_back(end_marker());
          end else if (is_blank(c)) begin
            ws = 1'b1;
            if (c == CH_NL) count_newline();
          end else begin
            tok_start = off;
            tok_len   = 16'd1;
            if (is_alpha(c)) phase = PH_IDENT;
            else if (is_num(c)) phase = PH_NUM_INT;
            else if (c == CH_DASH || c == CH_LBRACE) begin
              held  = c;
              phase = PH_HELD;
            end else begin
              batch.push_back(take_token(KIND_SYMBOL, c));
            end
          end
        end
      end
      if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
      foreach (batch[i]) expected_tokens.push_back(batch[i]);
    endfunction

    function void report(string why, result_t want, result_t got);
      errors++;
      if (errors <= 10) begin
        $display("%t %s", $realtime, why);
        $display("    exp kind=%0d sym=%02h off=%0d len=%0d line=%0d ws=%0b nl=%0b last=%0b",
                 want.kind, want.symbol_byte, want.start_offset, want.token_len,
                 want.line_no, want.ws_before, want.nl_before, want.last);
        $display("    got kind=%0d sym=%02h off=%0d len=%0d line=%0d ws=%0b nl=%0b last=%0b",
                 got.kind, got.symbol_byte, got.start_offset, got.token_len,
                 got.line_no, got.ws_before, got.nl_before, got.last);
      end
    endfunction

    function void check_token(result_t got);
      result_t want;
      if (expected_tokens.size() == 0) begin
        report("token with none pending", '0, got);
        return;
      end
      want = expected_tokens.pop_front();
      if (got.kind !== want.kind || got.symbol_byte !== want.symbol_byte ||
          got.start_offset !== want.start_offset || got.token_len !== want.token_len ||
          got.line_no !== want.line_no || got.ws_before !== want.ws_before ||
          got.nl_before !== want.nl_before || got.last !== want.last)
        report("token mismatch", want, got);
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, channels and the block
  // --------------------------------------------------------------------------
  logic clk;
  logic rst_n;

  stok_in_if  src_bus ();
  stok_out_if tok_bus ();

  source_tokenizer u_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (src_bus),
    .out_o  (tok_bus)
  );

  token_scoreboard sb;
  logic [7:0]      src_bytes[$];
  bit              burst;
  int              idle_cycles;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Sender side
  // --------------------------------------------------------------------------
  // Mostly back to back, sometimes a short gap, rarely a long one. A burst
  // stretch turns gaps off altogether.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (burst || r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  // Drive one byte and hold it until the block takes the beat.
  task automatic send_byte(input logic [7:0] c);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      src_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    src_bus.valid <= 1'b1;
    src_bus.ch    <= c;
    do @(posedge clk); while (!src_bus.ready);
    sb.note_byte(c);
  endtask

  task automatic send_queued(inout int count);
    while (src_bytes.size() > 0) begin
      send_byte(src_bytes.pop_front());
      count++;
    end
  endtask

  function automatic void push_text(string s);
    for (int i = 0; i < s.len(); i++) src_bytes.push_back(s[i]);
  endfunction

  function automatic logic [7:0] pick_alnum();
    case ($urandom_range(0, 2))
      0: return CH_UA + 8'($urandom_range(0, 25));
      1: return CH_LA + 8'($urandom_range(0, 25));
      default: return CH_0 + 8'($urandom_range(0, 9));
    endcase
  endfunction

  // Any nonzero byte that starts neither a word, a number nor a blank;
  // favor the bytes that steer the comment and number logic.
  function automatic logic [7:0] pick_symbol();
    logic [7:0] c;
    case ($urandom_range(0, 9))
      0: return CH_DASH;
      1: return CH_LBRACE;
      2: return CH_RBRACE;
      3: return CH_DOT;
      default: begin
        do c = 8'($urandom_range(1, 255));
        while (token_scoreboard::is_alpha(c) || token_scoreboard::is_num(c) ||
               token_scoreboard::is_blank(c));
        return c;
      end
    endcase
  endfunction

  function automatic logic [7:0] pick_blank();
    case ($urandom_range(0, 5))
      0: return CH_SPACE;
      1: return CH_TAB;
      2: return CH_NL;
      3: return CH_VT;
      4: return CH_FF;
      default: return CH_CR;
    endcase
  endfunction

  // Append one random, mostly well-formed piece of source text.
  function automatic void add_segment();
    logic [7:0] c;
    int         n;
    case ($urandom_range(0, 19))
      0, 1, 2, 3: begin
        src_bytes.push_back($urandom_range(0, 1) ? CH_UA + 8'($urandom_range(0, 25))
                                                 : CH_LA + 8'($urandom_range(0, 25)));
        n = $urandom_range(0, 7);
        repeat (n) src_bytes.push_back(pick_alnum());
      end
      4, 5, 6: begin
        n = $urandom_range(1, 4);
        repeat (n) src_bytes.push_back(CH_0 + 8'($urandom_range(0, 9)));
        if ($urandom_range(0, 1)) begin
          src_bytes.push_back(CH_DOT);
          n = $urandom_range(0, 3);
          repeat (n) src_bytes.push_back(CH_0 + 8'($urandom_range(0, 9)));
          if ($urandom_range(0, 5) == 0) src_bytes.push_back(CH_DOT);
        end
      end
      7, 8, 9: begin
        n = $urandom_range(1, 3);
        repeat (n) src_bytes.push_back(pick_blank());
      end
      10, 11: begin
        src_bytes.push_back(CH_DASH);
        src_bytes.push_back(CH_DASH);
        n = $urandom_range(0, 8);
        repeat (n) begin
          do c = 8'($urandom_range(1, 255)); while (c == CH_NL);
          src_bytes.push_back(c);
        end
        src_bytes.push_back(CH_NL);
      end
      12, 13: begin
        src_bytes.push_back(CH_LBRACE);
        src_bytes.push_back(CH_DASH);
        n = $urandom_range(0, 8);
        repeat (n) begin
          case ($urandom_range(0, 4))
            0: src_bytes.push_back(CH_DASH);
            1: src_bytes.push_back(CH_NL);
            2: src_bytes.push_back(CH_RBRACE);
            default: src_bytes.push_back(8'($urandom_range(1, 255)));
          endcase
        end
        src_bytes.push_back(CH_DASH);
        src_bytes.push_back(CH_RBRACE);
      end
      14, 15, 16: src_bytes.push_back(pick_symbol());
      17: begin
        // Lone dash or brace followed by a symbol, a letter or a digit.
        src_bytes.push_back($urandom_range(0, 1) ? CH_DASH : CH_LBRACE);
        src_bytes.push_back($urandom_range(0, 1) ? pick_symbol() : pick_alnum());
      end
      default: src_bytes.push_back(8'($urandom_range(1, 255)));
    endcase
  endfunction

  // Leave the lexer in a random phase right before the end byte.
  function automatic void add_ending();
    case ($urandom_range(0, 8))
      0: push_text(" ab");
      1: push_text(" 12.");
      2: push_text(" -");
      3: push_text(" {");
      4: push_text("--xy");
      5: push_text("{-a");
      6: push_text("{-a-");
      7: src_bytes.push_back(pick_blank());
      default: src_bytes.push_back(CH_SEMI);
    endcase
    src_bytes.push_back(CH_NUL);
    // Bytes after the end: each gets one more end marker.
    repeat ($urandom_range(1, 4)) src_bytes.push_back(8'($urandom_range(0, 255)));
  endfunction

  // --------------------------------------------------------------------------
  // Receiver side: ready runs and stalls of random length
  // --------------------------------------------------------------------------
  initial begin
    int run;
    int stall;
    tok_bus.ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 8);
      tok_bus.ready <= 1'b1;
      repeat (run) @(posedge clk);
      case ($urandom_range(0, 9))
        0, 1, 2, 3: stall = 0;
        9:          stall = $urandom_range(10, 40);
        default:    stall = $urandom_range(1, 3);
      endcase
      if (stall > 0) begin
        tok_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  // Check every token beat the block hands over.
  always @(posedge clk) begin
    result_t got;
    if (rst_n && tok_bus.valid && tok_bus.ready) begin
      got.kind         = kind_e'(tok_bus.kind);
      got.symbol_byte  = tok_bus.symbol_byte;
      got.start_offset = tok_bus.start_offset;
      got.token_len    = tok_bus.token_len;
      got.line_no      = tok_bus.line_no;
      got.ws_before    = tok_bus.ws_before;
      got.nl_before    = tok_bus.nl_before;
      got.last         = tok_bus.last;
      sb.check_token(got);
    end
  end

  // Watchdog: drop the run once no beat has moved on either side for too long.
  always @(posedge clk) begin
    if (!rst_n || (src_bus.valid && src_bus.ready) || (tok_bus.valid && tok_bus.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_MAX) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int  sent;
    sb            = new();
    burst         = 1'b0;
    sent          = 0;
    src_bus.valid = 1'b0;
    src_bus.ch    = CH_NUL;
    rst_n         = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: word and number extremes, dot endings, line and block
    // comments (newline inside, back to back, dash right before the close),
    // dash and brace that open nothing, a high byte and a low control byte.
    push_text("Az09 1..--x\n{-\n-}{--}-{a");
    src_bytes.push_back(8'hFF);
    src_bytes.push_back(CH_TAB);
    src_bytes.push_back(8'h01);
    send_queued(sent);

    // Random segments, now and then a stretch without gaps.
    sent = 0;
    while (sent < RAND_BYTES) begin
      burst = ($urandom_range(0, 7) == 0);
      add_segment();
      send_queued(sent);
    end

    burst = 1'b0;
    add_ending();
    send_queued(sent);
    src_bus.valid <= 1'b0;

    // Drain: wait out the pending tokens, then keep watching for strays.
    while (sb.expected_tokens.size() > 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);

    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
